### design/fks_pkg.sv
// Shared constants, types and controller-to-datapath command formats for the key search block.
`default_nettype none

package fks_pkg;

   // List storage geometry.
   localparam int MAX_LEN = 32;
   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int WORD_W = 32;
   localparam int POS_W = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [POS_W-1:0] pos_type;

   // Read address source for the element store.
   typedef enum logic {
      RD_IDX,
      RD_JM1
   } rd_src_type;

   // Operation on the main index counter.
   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_INC,
      IDX_SORT_START
   } idx_op_type;

   // Write port operation on the element store.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_LOAD,
      WR_SHIFT,
      WR_CUR
   } wr_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      wr_op_type  wr_op;
      logic       rd_en;
      rd_src_type rd_src;
      idx_op_type idx_op;
      logic       count_clr;
      logic       found_clr;
      logic       found_set;
      logic       cur_ld;
      logic       j_dec;
      logic       rsp_ld;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic key_hit;
      logic idx_last;
      logic greater;
      logic j_at_from;
      logic sort_empty;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

### design/fks_csr.sv
// APB register holding the search key.
`default_nettype none

module fks_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [fks_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [fks_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic      [fks_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                      pready,
   output fks_pkg::word_type                         key
);
   import fks_pkg::*;

   word_type key_ff;
   word_type key_in;
   logic     key_sel;

   // The key register is the only word; the upper address bit selects nothing.
   assign key_sel = (paddr[CSR_ADDR_W-1] == 1'b0);

   always_comb begin
      key_in = key_ff;
      if (psel && penable && pwrite && key_sel) begin
         key_in = word_type'(pwdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // Reads return the key, or zero outside the register map.
   assign prdata = key_sel ? CSR_DATA_W'(key_ff) : '0;
   assign pready = 1'b1;
   assign key    = key_ff;

endmodule

`default_nettype wire

### design/fks_ctrl.sv
// Controller state machine sequencing load, search, suffix sort and emission.
`default_nettype none

module fks_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last,
   output logic                     req_stall,
   input  wire fks_pkg::status_type status,
   output fks_pkg::cmd_type         cmd
);
   import fks_pkg::*;

   typedef enum logic [3:0] {
      S_LOAD,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_SORT_CHK,
      S_SORT_RDI,
      S_SORT_LDI,
      S_SORT_RDJ,
      S_SORT_CMP,
      S_SORT_PUT,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      accept;

   assign accept = req_valid && !req_stall_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd = '{wr_op: WR_NONE, rd_en: 1'b0, rd_src: RD_IDX, idx_op: IDX_HOLD,
              count_clr: 1'b0, found_clr: 1'b0, found_set: 1'b0, cur_ld: 1'b0,
              j_dec: 1'b0, rsp_ld: 1'b0};
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               cmd.wr_op = WR_LOAD;
               if (req_last) begin
                  cmd.found_clr = 1'b1;
                  cmd.idx_op    = IDX_ZERO;
                  state_in      = S_SEARCH_RD;
               end
            end
         end
         S_SEARCH_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SEARCH_CMP;
         end
         S_SEARCH_CMP: begin
            if (status.key_hit) begin
               cmd.found_set = 1'b1;
               state_in      = S_SORT_CHK;
            end else if (status.idx_last) begin
               cmd.idx_op = IDX_ZERO;
               state_in   = S_EMIT_RD;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SEARCH_RD;
            end
         end
         // Skip the sort when fewer than two elements follow the key.
         S_SORT_CHK: begin
            if (status.sort_empty) begin
               cmd.idx_op = IDX_ZERO;
               state_in   = S_EMIT_RD;
            end else begin
               cmd.idx_op = IDX_SORT_START;
               state_in   = S_SORT_RDI;
            end
         end
         S_SORT_RDI: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SORT_LDI;
         end
         S_SORT_LDI: begin
            cmd.cur_ld = 1'b1;
            state_in   = S_SORT_RDJ;
         end
         S_SORT_RDJ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_JM1;
            state_in   = S_SORT_CMP;
         end
         // Shift the larger neighbor up, or drop the held element into its slot.
         S_SORT_CMP: begin
            if (status.greater) begin
               cmd.wr_op = WR_SHIFT;
               cmd.j_dec = 1'b1;
               state_in  = status.j_at_from ? S_SORT_PUT : S_SORT_RDJ;
            end else begin
               cmd.wr_op = WR_CUR;
               if (status.idx_last) begin
                  cmd.idx_op = IDX_ZERO;
                  state_in   = S_EMIT_RD;
               end else begin
                  cmd.idx_op = IDX_INC;
                  state_in   = S_SORT_RDI;
               end
            end
         end
         S_SORT_PUT: begin
            cmd.wr_op = WR_CUR;
            if (status.idx_last) begin
               cmd.idx_op = IDX_ZERO;
               state_in   = S_EMIT_RD;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SORT_RDI;
            end
         end
         // Read the next element only once the output register can take it.
         S_EMIT_RD: begin
            if (status.rsp_free) begin
               cmd.rd_en = 1'b1;
               state_in  = S_EMIT_LD;
            end
         end
         S_EMIT_LD: begin
            cmd.rsp_ld = 1'b1;
            if (status.idx_last) begin
               cmd.count_clr = 1'b1;
               state_in      = S_LOAD;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // State and registered stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_LOAD);
      end
   end

   assign req_stall = req_stall_ff;

endmodule

`default_nettype wire

### design/fks_dpath.sv
// Datapath: element store, counters, compare logic and the result register.
`default_nettype none

module fks_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fks_pkg::cmd_type      cmd,
   output fks_pkg::status_type        status,
   input  wire fks_pkg::word_type     key,
   input  wire fks_pkg::word_type     req_value,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output fks_pkg::word_type          rsp_value_res,
   output fks_pkg::pos_type           rsp_position,
   output logic                       rsp_found,
   output fks_pkg::pos_type           rsp_key_position,
   output logic                       rsp_last_res
);
   import fks_pkg::*;

   word_type store_ff [MAX_LEN];
   word_type rd_data_ff;
   word_type cur_ff;
   cnt_type  count_ff, count_in;
   cnt_type  idx_ff, idx_in;
   cnt_type  j_ff, j_in;
   idx_type  kpos_ff, kpos_in;
   logic     found_ff, found_in;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_value_ff;
   pos_type  rsp_position_ff;
   logic     rsp_found_ff;
   pos_type  rsp_key_position_ff;
   logic     rsp_last_ff;

   cnt_type  sort_start;
   cnt_type  j_m1;
   logic     room;
   logic     wr_en;
   idx_type  wr_addr;
   word_type wr_data;
   idx_type  rd_addr;

   assign sort_start = cnt_type'(kpos_ff) + cnt_type'(2);
   assign j_m1       = j_ff - cnt_type'(1);
   assign room       = (count_ff < cnt_type'(MAX_LEN));

   // Write port: loading appends, sorting writes at the hole position.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = req_value;
      case (cmd.wr_op)
         WR_LOAD: begin
            wr_en = room;
         end
         WR_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
         end
         WR_CUR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = cur_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign rd_addr = (cmd.rd_src == RD_JM1) ? j_m1[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   // Element store with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // Counters and search result.
   always_comb begin
      count_in = count_ff;
      if (cmd.count_clr) begin
         count_in = '0;
      end else if (cmd.wr_op == WR_LOAD && room) begin
         count_in = count_ff + cnt_type'(1);
      end

      case (cmd.idx_op)
         IDX_ZERO:       idx_in = '0;
         IDX_INC:        idx_in = idx_ff + cnt_type'(1);
         IDX_SORT_START: idx_in = sort_start;
         default:        idx_in = idx_ff;
      endcase

      j_in = j_ff;
      if (cmd.cur_ld) begin
         j_in = idx_ff;
      end else if (cmd.j_dec) begin
         j_in = j_m1;
      end

      found_in = found_ff;
      kpos_in  = kpos_ff;
      if (cmd.found_clr) begin
         found_in = 1'b0;
         kpos_in  = '0;
      end else if (cmd.found_set) begin
         found_in = 1'b1;
         kpos_in  = idx_ff[IDX_W-1:0];
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_ld) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         j_ff         <= '0;
         found_ff     <= 1'b0;
         kpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         j_ff         <= j_in;
         found_ff     <= found_in;
         kpos_ff      <= kpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Held insertion element and result payload.
   always_ff @(posedge clock) begin
      if (cmd.cur_ld) begin
         cur_ff <= rd_data_ff;
      end
      if (cmd.rsp_ld) begin
         rsp_value_ff        <= rd_data_ff;
         rsp_position_ff     <= pos_type'(idx_ff);
         rsp_found_ff        <= found_ff;
         rsp_key_position_ff <= found_ff ? pos_type'(kpos_ff) : '0;
         rsp_last_ff         <= status.idx_last;
      end
   end

   // Status back to the controller.
   always_comb begin
      status.key_hit    = (rd_data_ff == key);
      status.idx_last   = ((idx_ff + cnt_type'(1)) == count_ff);
      status.greater    = (rd_data_ff > cur_ff);
      status.j_at_from  = (j_ff == sort_start);
      status.sort_empty = (sort_start >= count_ff);
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value_res    = rsp_value_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_key_position = rsp_key_position_ff;
   assign rsp_last_res     = rsp_last_ff;

endmodule

`default_nettype wire

### design/find_key_then_sort_suffix.sv
// Top level of the key search and suffix sort block.
`default_nettype none

// Elements arrive one per cycle while the input is not stalled and are stored in a
// 32-entry memory; further elements of an overlong list are dropped, and the closing
// transaction still ends it. After the closing transaction the block stalls its input
// while it scans for the first element equal to the key, then, if the key is found and
// at least two elements follow it, insertion-sorts the elements after the key through
// the memory's read and write ports (each element is read, held, compared with its
// neighbors and placed, and each larger neighbor is shifted up one place), then emits
// the list, reading each element before it loads the output register. The input is
// taken again as soon as the last result sits in the output register.

module find_key_then_sort_suffix (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [31:0]              req_value,
   input  wire logic                            req_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [31:0]                   rsp_value_res,
   output logic [4:0]                           rsp_position,
   output logic                                 rsp_found,
   output logic [4:0]                           rsp_key_position,
   output logic                                 rsp_last_res,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [fks_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [fks_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [fks_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import fks_pkg::*;

   cmd_type    cmd;
   status_type status;
   word_type   key;

   // Search key register.
   fks_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   // Sequencer.
   fks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and compare datapath.
   fks_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .key              (key),
      .req_value        (req_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_value_res    (rsp_value_res),
      .rsp_position     (rsp_position),
      .rsp_found        (rsp_found),
      .rsp_key_position (rsp_key_position),
      .rsp_last_res     (rsp_last_res)
   );

endmodule

`default_nettype wire

### design/fks_checker.sv
// Port-level checker for the key search block and its bind to the top level.
`default_nettype none

module fks_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_value_res,
   input wire logic [4:0]  rsp_position,
   input wire logic        rsp_found,
   input wire logic [4:0]  rsp_key_position
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_res)
         && $stable(rsp_position))
      else $error("stalled result changed");

   // Without a match the key position reads zero.
   a_kpos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_key_position == 5'd0)
      else $error("key position nonzero without a match");

   // The output register needs a fetch between transactions.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("back-to-back results");

   // Closing a list makes the input busy on the next cycle.
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input not stalled after closing transaction");

endmodule

bind find_key_then_sort_suffix fks_checker u_fks_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_value_res    (rsp_value_res),
   .rsp_position     (rsp_position),
   .rsp_found        (rsp_found),
   .rsp_key_position (rsp_key_position)
);

`default_nettype wire

### verif/find_key_then_sort_suffix_checker.sv
// Checker for the key search block: predicts every emitted list and compares it with the result channel.
`timescale 1ns / 1ps

module find_key_then_sort_suffix_checker
   import fks_pkg::*;
#(
   parameter logic [CSR_ADDR_W-1:0] SEARCH_KEY_ADDR = '0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic signed [31:0]     req_value,
   input  wire logic                   req_last,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic signed [31:0]     rsp_value_res,
   input  wire logic [4:0]             rsp_position,
   input  wire logic                   rsp_found,
   input  wire logic [4:0]             rsp_key_position,
   input  wire logic                   rsp_last_res,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   input  wire logic                   pready,
   output int                          fail_count,
   output int                          pending
);

   // One emitted list element as the result channel should show it.
   typedef struct packed {
      word_type value;
      pos_type  position;
      logic     found;
      pos_type  key_position;
      logic     closing;
   } list_element_type;

   word_type         key_setting;
   word_type         gathered [MAX_LEN];
   int               gathered_count;
   list_element_type expected_elements [$];
   int               mismatches = 0;

   // Finds the first copy of the key, sorts what follows it and queues the whole list.
   task automatic sort_after_key();
      word_type         ordered [MAX_LEN];
      word_type         cur;
      list_element_type element;
      logic             hit;
      int               key_index;
      int               i;
      int               j;
      ordered = gathered;
      hit = 1'b0;
      key_index = 0;
      for (i = 0; i < gathered_count; i++) begin
         if (!hit && ordered[i] == key_setting) begin
            hit = 1'b1;
            key_index = i;
         end
      end
      // Insertion sort of the suffix in signed order.
      if (hit) begin
         for (i = key_index + 2; i < gathered_count; i++) begin
            cur = ordered[i];
            j = i;
            while (j > key_index + 1 && ordered[j-1] > cur) begin
               ordered[j] = ordered[j-1];
               j--;
            end
            ordered[j] = cur;
         end
      end
      for (i = 0; i < gathered_count; i++) begin
         element.value = ordered[i];
         element.position = pos_type'(i);
         element.found = hit;
         element.key_position = hit ? pos_type'(key_index) : '0;
         element.closing = (i == gathered_count - 1);
         expected_elements.push_back(element);
      end
   endtask

   // Compares one accepted result transaction with the oldest expected element.
   task automatic check_emitted_element();
      list_element_type want;
      if (expected_elements.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual value %0d position %0d found %0b key_position %0d last %0b",
                  $time, rsp_value_res, rsp_position, rsp_found, rsp_key_position,
                  rsp_last_res);
         mismatches++;
      end else begin
         want = expected_elements.pop_front();
         if (rsp_value_res !== want.value || rsp_position !== want.position ||
             rsp_found !== want.found || rsp_key_position !== want.key_position ||
             rsp_last_res !== want.closing) begin
            $display("%0t: result mismatch: expected value %0d position %0d found %0b key_position %0d last %0b",
                     $time, want.value, want.position, want.found, want.key_position,
                     want.closing);
            $display("%0t:                  actual value %0d position %0d found %0b key_position %0d last %0b",
                     $time, rsp_value_res, rsp_position, rsp_found, rsp_key_position,
                     rsp_last_res);
            mismatches++;
         end
      end
   endtask

   // Follows register writes and both channels at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         key_setting = '0;
         gathered_count = 0;
         expected_elements.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_emitted_element();
         end
         if (psel && penable && pwrite && pready && paddr == SEARCH_KEY_ADDR) begin
            key_setting = word_type'(pwdata);
         end
         // Elements past the store size are dropped, but a closing one still ends the list.
         if (req_valid && !req_stall) begin
            if (gathered_count < MAX_LEN) begin
               gathered[gathered_count] = req_value;
               gathered_count++;
            end
            if (req_last) begin
               sort_after_key();
               gathered_count = 0;
            end
         end
      end
      pending <= expected_elements.size();
      fail_count <= mismatches;
   end

endmodule

### verif/tb_find_key_then_sort_suffix.sv
// Testbench top for the key search block: drives lists and key settings and gives the verdict.
`timescale 1ns / 1ps

module tb_find_key_then_sort_suffix;
   import fks_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] SEARCH_KEY_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
   localparam word_type MOST_NEGATIVE = 32'sh8000_0000;
   localparam word_type MOST_POSITIVE = 32'sh7FFF_FFFF;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic signed [31:0]     req_value;
   logic                   req_last;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [31:0]     rsp_value_res;
   logic [4:0]             rsp_position;
   logic                   rsp_found;
   logic [4:0]             rsp_key_position;
   logic                   rsp_last_res;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_W-1:0]  paddr;
   logic [CSR_DATA_W-1:0]  pwdata;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   int       fail_count;
   int       pending;
   int       idle_pct;
   int       stall_pct;
   int       quiet_cycles;
   word_type key_now;
   word_type list_q [$];

   find_key_then_sort_suffix i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value_res    (rsp_value_res),
      .rsp_position     (rsp_position),
      .rsp_found        (rsp_found),
      .rsp_key_position (rsp_key_position),
      .rsp_last_res     (rsp_last_res),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   find_key_then_sort_suffix_checker #(
      .SEARCH_KEY_ADDR (SEARCH_KEY_ADDR)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value_res    (rsp_value_res),
      .rsp_position     (rsp_position),
      .rsp_found        (rsp_found),
      .rsp_key_position (rsp_key_position),
      .rsp_last_res     (rsp_last_res),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall = (int'($urandom_range(99)) < stall_pct);
   end

   // Ends the run when no transaction has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one element, with random idle cycles ahead of it, and returns once it is taken.
   // Valid stays high on return; the caller either offers the next element or lowers it.
   task automatic send_element(input word_type value, input logic closing);
      while (int'($urandom_range(99)) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = value;
      req_last = closing;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_list();
      foreach (list_q[i]) begin
         send_element(list_q[i], i == list_q.size() - 1);
      end
   endtask

   // Holds the input until every expected result has come and the block has settled.
   task automatic wait_for_results();
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the edge with pready high.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_key(input word_type key);
      csr_write(SEARCH_KEY_ADDR, key);
      key_now = key;
   endtask

   // Values near the key, duplicates of it and the extremes, so that searches hit often.
   function automatic word_type near_key_value();
      case ($urandom_range(7))
         0, 1: return key_now;
         2: return key_now + 1;
         3: return key_now - 1;
         4: return MOST_NEGATIVE;
         5: return MOST_POSITIVE;
         default: return word_type'(int'($urandom_range(20)) - 10);
      endcase
   endfunction

   // Random lists, mostly short, some up to the store size and a few overlong ones.
   task automatic run_random_lists(input int target, input bit pause_once);
      int stored;
      int len;
      int pick;
      int lists;
      bit near_key;
      stored = 0;
      lists = 0;
      while (stored < target) begin
         pick = $urandom_range(99);
         if (pick < 70) len = $urandom_range(8, 1);
         else if (pick < 92) len = $urandom_range(32, 9);
         else len = $urandom_range(40, 33);
         near_key = ($urandom_range(99) < 60);
         list_q.delete();
         repeat (len) begin
            list_q.push_back(near_key ? near_key_value() : word_type'($urandom));
         end
         send_list();
         stored += (len < MAX_LEN) ? len : MAX_LEN;
         lists++;
         if (pause_once && lists == 5) begin
            wait_for_results();
         end
      end
   endtask

   // Stimulus: directed lists, then random lists over several idle and stall settings.
   initial begin
      req_valid = 1'b0;
      req_value = '0;
      req_last = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      key_now = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset key of zero: key alone, key with duplicates and extremes after it,
      // key absent, key as the closing element, a single absent element.
      list_q = '{0};
      send_list();
      list_q = '{5, 0, 7, -1, MOST_POSITIVE, MOST_NEGATIVE, 0, 3};
      send_list();
      list_q = '{1, 2, 3};
      send_list();
      list_q = '{9, 8, 0};
      send_list();
      list_q = '{MOST_NEGATIVE};
      send_list();
      wait_for_results();

      // A write past the register list must leave the key alone.
      csr_write(UNMAPPED_ADDR, 32'h1234_5678);
      set_key(MOST_NEGATIVE);
      list_q = '{MOST_POSITIVE, MOST_NEGATIVE, 5, MOST_NEGATIVE, -7, MOST_POSITIVE};
      send_list();
      run_random_lists(55, 1'b0);

      // Sender idle most of the time, with one full pause in the middle.
      wait_for_results();
      idle_pct = 78;
      stall_pct = 0;
      set_key(MOST_POSITIVE);
      run_random_lists(60, 1'b1);

      // Receiver stalling most of the time.
      wait_for_results();
      idle_pct = 0;
      stall_pct = 78;
      set_key(word_type'($urandom));
      run_random_lists(60, 1'b0);

      // Both sides with light gaps.
      wait_for_results();
      idle_pct = 10;
      stall_pct = 10;
      set_key(3);
      run_random_lists(60, 1'b0);

      wait_for_results();
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
